>>> rtl/core/lpcsf_pkg.sv
// ----------------------------------------------------------------------------
// lpcsf_pkg
// Shared types, constants and coefficient ROM for the LPC synthesis filter.
// ----------------------------------------------------------------------------
package lpcsf_pkg;

  localparam int ORDER_DEFAULT = 10;
  localparam int ROM_TAPS      = 16;
  localparam int ROM_SETS      = 8;
  localparam int TAP_W         = $clog2(ROM_TAPS);

  localparam int X_W      = 16;
  localparam int GAIN_W   = 15;
  localparam int SET_W    = 3;
  localparam int FUNC_W   = 2;
  localparam int COEF_W   = 16;
  localparam int HIST_W   = 20;
  localparam int OUT_W    = 16;
  localparam int O_W      = 18;
  localparam int MUL_A_W  = 20;
  localparam int MUL_B_W  = 16;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int FRAC_W   = 15;
  localparam int IN_DATA_W = 24;

  localparam int ROUND_HALF = 16384;
  localparam int HIST_MAX   = 524287;
  localparam int HIST_MIN   = -524288;
  localparam int S_MAX      = 32767;
  localparam int S_MIN      = -32768;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd8192;
  localparam logic [SET_W-1:0]  SET_SCHWA  = 3'd5;

  localparam logic signed [MUL_B_W-1:0] K_SCALE           = 16'sd4915;
  localparam logic signed [MUL_B_W-1:0] K_ALPHA           = 16'sd9830;
  localparam logic signed [MUL_B_W-1:0] K_ONE_MINUS_ALPHA = 16'sd22938;
  localparam logic signed [MUL_B_W-1:0] K_OLD             = 16'sd26214;
  localparam logic signed [MUL_B_W-1:0] K_NEW             = 16'sd6554;
  localparam logic signed [OUT_W-1:0]   K_CLIP            = 16'sd29491;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FILTER = 2'd0,
    FUNC_BLEND  = 2'd1,
    FUNC_LOAD   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GAIN,
    MUL_TAP,
    MUL_SCALE,
    MUL_SMOOTH_OLD,
    MUL_SMOOTH_NEW,
    MUL_BLEND_OLD,
    MUL_BLEND_NEW
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_LOAD2,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     capture;
    logic     hist_push;
    logic     o_load;
    logic     out_load;
    logic     coef_load;
    logic     coef_write;
  } cmd_t;

  localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_SETS][ROM_TAPS] = '{
    '{16'sd9830,  -16'sd4915, 16'sd2621, -16'sd1311, 16'sd655, -16'sd328,
      16'sd164,   -16'sd66,   16'sd33,   -16'sd16,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd13107, -16'sd6554, 16'sd3277, -16'sd1638, 16'sd819, -16'sd393,
      16'sd197,   -16'sd98,   16'sd49,   -16'sd23,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd11469, -16'sd5898, 16'sd2949, -16'sd1475, 16'sd721, -16'sd360,
      16'sd164,   -16'sd98,   16'sd49,   -16'sd23,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd10486, -16'sd5243, 16'sd2621, -16'sd1311, 16'sd655, -16'sd328,
      16'sd164,   -16'sd66,   16'sd33,   -16'sd16,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd9175,  -16'sd4588, 16'sd2294, -16'sd1147, 16'sd557, -16'sd262,
      16'sd131,   -16'sd66,   16'sd33,   -16'sd16,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd9830,  -16'sd4915, 16'sd2458, -16'sd1212, 16'sd590, -16'sd295,
      16'sd131,   -16'sd66,   16'sd33,   -16'sd16,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd6554,  -16'sd3277, 16'sd1638, -16'sd819,  16'sd393, -16'sd197,
      16'sd98,    -16'sd49,   16'sd23,   -16'sd10,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd12452, -16'sd6226, 16'sd3113, -16'sd1540, 16'sd754, -16'sd360,
      16'sd197,   -16'sd98,   16'sd49,   -16'sd23,   16'sd0,   16'sd0,
      16'sd0,     16'sd0,     16'sd0,    16'sd0}
  };

  function automatic logic signed [COEF_W-1:0] rom_coef(input logic [SET_W-1:0] sel,
                                                         input logic [TAP_W-1:0] tap);
    return COEF_ROM[sel][tap];
  endfunction

endpackage

>>> rtl/core/lpcsf_dp.sv
// ----------------------------------------------------------------------------
// lpcsf_dp
// Datapath: shared multiplier, accumulator, coefficient and history stores,
// smoother and output register.
// ----------------------------------------------------------------------------
module lpcsf_dp #(
  parameter int ORDER = lpcsf_pkg::ORDER_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lpcsf_pkg::cmd_t                        cmd,
  input  logic [(ORDER > 1 ? $clog2(ORDER) : 1)-1:0] idx,
  input  logic signed [lpcsf_pkg::X_W-1:0]       in_excitation,
  input  logic [lpcsf_pkg::SET_W-1:0]            in_set,
  input  logic                                   cfg_we,
  input  logic [lpcsf_pkg::GAIN_W-1:0]           cfg_gain,
  output logic [lpcsf_pkg::OUT_W-1:0]            out_data
);

  localparam int ACC_W  = lpcsf_pkg::PROD_W + $clog2(ORDER + 1);
  localparam int HIST_W = lpcsf_pkg::HIST_W;
  localparam int COEF_W = lpcsf_pkg::COEF_W;
  localparam int OUT_W  = lpcsf_pkg::OUT_W;
  localparam int O_W    = lpcsf_pkg::O_W;
  localparam int A_W    = lpcsf_pkg::MUL_A_W;
  localparam int B_W    = lpcsf_pkg::MUL_B_W;
  localparam int P_W    = lpcsf_pkg::PROD_W;
  localparam int TAP_W  = lpcsf_pkg::TAP_W;

  logic signed [lpcsf_pkg::X_W-1:0]  x_r;
  logic [lpcsf_pkg::SET_W-1:0]       set_r;
  logic [lpcsf_pkg::GAIN_W-1:0]      gain_r;
  logic signed [COEF_W-1:0]          coef_r [ORDER];
  logic signed [HIST_W-1:0]          hist_r [ORDER];
  logic signed [HIST_W-1:0]          y_r;
  logic signed [O_W-1:0]             o_r;
  logic signed [OUT_W-1:0]           s_r;
  logic [OUT_W-1:0]                  out_data_r;
  logic signed [P_W-1:0]             prod_r;
  lpcsf_pkg::acc_op_t                acc_op_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           acc_nxt;

  logic signed [A_W-1:0]             mul_a;
  logic signed [B_W-1:0]             mul_b;
  logic signed [COEF_W-1:0]          rom_tap;
  logic signed [ACC_W-1:0]           acc_rnd;
  logic signed [P_W-1:0]             prod_rnd;
  logic signed [HIST_W-1:0]          y_sat;
  logic signed [OUT_W-1:0]           s_sat;
  logic signed [OUT_W-1:0]           s_clip;

  assign rom_tap = lpcsf_pkg::rom_coef(set_r, TAP_W'(idx));

  always_comb begin
    unique case (cmd.mul_sel)
      lpcsf_pkg::MUL_GAIN: begin
        mul_a = A_W'(x_r);
        mul_b = $signed({1'b0, gain_r});
      end
      lpcsf_pkg::MUL_TAP: begin
        mul_a = hist_r[idx];
        mul_b = coef_r[idx];
      end
      lpcsf_pkg::MUL_SCALE: begin
        mul_a = y_r;
        mul_b = lpcsf_pkg::K_SCALE;
      end
      lpcsf_pkg::MUL_SMOOTH_OLD: begin
        mul_a = A_W'(s_r);
        mul_b = lpcsf_pkg::K_ONE_MINUS_ALPHA;
      end
      lpcsf_pkg::MUL_SMOOTH_NEW: begin
        mul_a = A_W'(o_r);
        mul_b = lpcsf_pkg::K_ALPHA;
      end
      lpcsf_pkg::MUL_BLEND_OLD: begin
        mul_a = A_W'(coef_r[idx]);
        mul_b = lpcsf_pkg::K_OLD;
      end
      lpcsf_pkg::MUL_BLEND_NEW: begin
        mul_a = A_W'(rom_tap);
        mul_b = lpcsf_pkg::K_NEW;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (acc_op_r)
      lpcsf_pkg::ACC_LOAD:  acc_nxt = ACC_W'(prod_r);
      lpcsf_pkg::ACC_LOAD2: acc_nxt = ACC_W'(prod_r) <<< 1;
      lpcsf_pkg::ACC_ADD:   acc_nxt = acc_r + ACC_W'(prod_r);
      lpcsf_pkg::ACC_SUB:   acc_nxt = acc_r - ACC_W'(prod_r);
      default:              acc_nxt = acc_r;
    endcase
  end

  // round half up to Q.15
  assign acc_rnd  = (acc_r + ACC_W'(lpcsf_pkg::ROUND_HALF)) >>> lpcsf_pkg::FRAC_W;
  assign prod_rnd = (prod_r + P_W'(lpcsf_pkg::ROUND_HALF)) >>> lpcsf_pkg::FRAC_W;

  always_comb begin
    priority if (acc_rnd > ACC_W'(lpcsf_pkg::HIST_MAX)) begin
      y_sat = HIST_W'(lpcsf_pkg::HIST_MAX);
    end else if (acc_rnd < ACC_W'(lpcsf_pkg::HIST_MIN)) begin
      y_sat = HIST_W'(lpcsf_pkg::HIST_MIN);
    end else begin
      y_sat = HIST_W'(acc_rnd);
    end
  end

  always_comb begin
    priority if (acc_rnd > ACC_W'(lpcsf_pkg::S_MAX)) begin
      s_sat = OUT_W'(lpcsf_pkg::S_MAX);
    end else if (acc_rnd < ACC_W'(lpcsf_pkg::S_MIN)) begin
      s_sat = OUT_W'(lpcsf_pkg::S_MIN);
    end else begin
      s_sat = OUT_W'(acc_rnd);
    end
  end

  always_comb begin
    priority if (s_sat > lpcsf_pkg::K_CLIP) begin
      s_clip = lpcsf_pkg::K_CLIP;
    end else if (s_sat < -lpcsf_pkg::K_CLIP) begin
      s_clip = -lpcsf_pkg::K_CLIP;
    end else begin
      s_clip = s_sat;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (cmd.capture) begin
      x_r   <= in_excitation;
      set_r <= in_set;
    end
    if (cmd.hist_push) begin
      y_r <= y_sat;
    end
    if (cmd.o_load) begin
      o_r <= O_W'(prod_rnd);
    end
    if (cmd.out_load) begin
      out_data_r <= s_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_r <= lpcsf_pkg::ACC_NONE;
      gain_r   <= lpcsf_pkg::GAIN_RESET;
      s_r      <= '0;
      for (int i = 0; i < ORDER; i++) begin
        coef_r[i] <= lpcsf_pkg::rom_coef(lpcsf_pkg::SET_SCHWA, TAP_W'(i));
        hist_r[i] <= '0;
      end
    end else begin
      acc_op_r <= cmd.acc_op;
      if (cfg_we) begin
        gain_r <= cfg_gain;
      end
      if (cmd.out_load) begin
        s_r <= s_sat;
      end
      if (cmd.hist_push) begin
        hist_r[0] <= y_sat;
        for (int i = 1; i < ORDER; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
      end
      if (cmd.coef_load) begin
        for (int i = 0; i < ORDER; i++) begin
          coef_r[i] <= lpcsf_pkg::rom_coef(set_r, TAP_W'(i));
        end
      end else if (cmd.coef_write) begin
        coef_r[idx] <= COEF_W'(acc_rnd);
      end
    end
  end

  assign out_data = out_data_r;

endmodule

>>> rtl/core/lpcsf_ctrl.sv
// ----------------------------------------------------------------------------
// lpcsf_ctrl
// Controller: sequences filter, blend and load words over the datapath.
// ----------------------------------------------------------------------------
module lpcsf_ctrl #(
  parameter int ORDER = lpcsf_pkg::ORDER_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  input  logic [lpcsf_pkg::FUNC_W-1:0]               in_func,
  output logic                                       in_tready,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output lpcsf_pkg::cmd_t                            cmd,
  output logic [(ORDER > 1 ? $clog2(ORDER) : 1)-1:0] idx
);

  localparam int IDX_W = ORDER > 1 ? $clog2(ORDER) : 1;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_GAIN  = 15'b000000000000010,
    S_MAC   = 15'b000000000000100,
    S_DRAIN = 15'b000000000001000,
    S_HIST  = 15'b000000000010000,
    S_SCALE = 15'b000000000100000,
    S_SM1   = 15'b000000001000000,
    S_SM2   = 15'b000000010000000,
    S_SM3   = 15'b000000100000000,
    S_FIN   = 15'b000001000000000,
    S_LOAD  = 15'b000010000000000,
    S_BA    = 15'b000100000000000,
    S_BB    = 15'b001000000000000,
    S_BD    = 15'b010000000000000,
    S_BR    = 15'b100000000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               last_tap;

  assign last_tap = (cnt_r == IDX_W'(ORDER - 1));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    in_tready      = 1'b0;
    cmd.mul_sel    = lpcsf_pkg::MUL_NONE;
    cmd.acc_op     = lpcsf_pkg::ACC_NONE;
    cmd.capture    = 1'b0;
    cmd.hist_push  = 1'b0;
    cmd.o_load     = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.coef_load  = 1'b0;
    cmd.coef_write = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cnt_nxt   = '0;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          unique case (lpcsf_pkg::func_t'(in_func))
            lpcsf_pkg::FUNC_FILTER: state_nxt = S_GAIN;
            lpcsf_pkg::FUNC_BLEND:  state_nxt = S_BA;
            lpcsf_pkg::FUNC_LOAD:   state_nxt = S_LOAD;
            default:                state_nxt = S_IDLE;
          endcase
        end
      end
      S_GAIN: begin
        cmd.mul_sel = lpcsf_pkg::MUL_GAIN;
        cmd.acc_op  = lpcsf_pkg::ACC_LOAD2;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.mul_sel = lpcsf_pkg::MUL_TAP;
        cmd.acc_op  = lpcsf_pkg::ACC_SUB;
        if (last_tap) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DRAIN: state_nxt = S_HIST;
      S_HIST: begin
        cmd.hist_push = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        cmd.mul_sel = lpcsf_pkg::MUL_SCALE;
        state_nxt   = S_SM1;
      end
      S_SM1: begin
        cmd.o_load  = 1'b1;
        cmd.mul_sel = lpcsf_pkg::MUL_SMOOTH_OLD;
        cmd.acc_op  = lpcsf_pkg::ACC_LOAD;
        state_nxt   = S_SM2;
      end
      S_SM2: begin
        cmd.mul_sel = lpcsf_pkg::MUL_SMOOTH_NEW;
        cmd.acc_op  = lpcsf_pkg::ACC_ADD;
        state_nxt   = S_SM3;
      end
      S_SM3: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd.coef_load = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_BA: begin
        cmd.mul_sel = lpcsf_pkg::MUL_BLEND_OLD;
        cmd.acc_op  = lpcsf_pkg::ACC_LOAD;
        state_nxt   = S_BB;
      end
      S_BB: begin
        cmd.mul_sel = lpcsf_pkg::MUL_BLEND_NEW;
        cmd.acc_op  = lpcsf_pkg::ACC_ADD;
        state_nxt   = S_BD;
      end
      S_BD: state_nxt = S_BR;
      S_BR: begin
        cmd.coef_write = 1'b1;
        if (last_tap) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + IDX_W'(1);
          state_nxt = S_BA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign idx        = cnt_r;
  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/core/lpc_synthesis_filter_core.sv
// ----------------------------------------------------------------------------
// lpc_synthesis_filter_core - LPC all-pole synthesis filter, one shared MAC
// Filter word steps GAIN, MAC per tap, DRAIN, HIST, SCALE, SM1, SM2, SM3 and
// FIN; the next word is taken after FIN, later while the output word is held.
// Blend word steps BA, BB, BD, BR per tap, load word LOAD; unused func dropped.
// Sync reset: schwa coefficients, clear history and smoother, gain 0.5.
// ----------------------------------------------------------------------------
module lpc_synthesis_filter_core #(
  parameter int ORDER = lpcsf_pkg::ORDER_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lpcsf_pkg::IN_DATA_W-1:0]     in_tdata,   // excitation, coefficient_set
  input  logic [lpcsf_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpcsf_pkg::OUT_W-1:0]         out_tdata,  // sample_out
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpcsf_pkg::GAIN_W-1:0]        cfg_data    // input_gain
);

  localparam int IDX_W = ORDER > 1 ? $clog2(ORDER) : 1;

  lpcsf_pkg::cmd_t   cmd;
  logic [IDX_W-1:0]  idx;

  assign cfg_ready = 1'b1;

  lpcsf_ctrl #(
    .ORDER (ORDER)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .idx        (idx)
  );

  lpcsf_dp #(
    .ORDER (ORDER)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .idx           (idx),
    .in_excitation ($signed(in_tdata[lpcsf_pkg::X_W-1:0])),
    .in_set        (in_tdata[lpcsf_pkg::X_W +: lpcsf_pkg::SET_W]),
    .cfg_we        (cfg_valid),
    .cfg_gain      (cfg_data),
    .out_data      (out_tdata)
  );

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= lpcsf_pkg::K_CLIP) &&
                   ($signed(out_tdata) >= -lpcsf_pkg::K_CLIP))
    else $error("output word outside clip range");

  a_busy_after_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == lpcsf_pkg::FUNC_FILTER)) |=> !in_tready)
    else $error("input accepted while a filter word is in progress");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised without a filter word in progress");

endmodule
